/* hdl/humidity_pressure_temp_compensation_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef HUMIDITY_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define HUMIDITY_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// Checked at every clock edge outside reset.
`define HPTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hptc check failed");

// Checked at every clock edge, reset included.
`define HPTC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hptc reset check failed");

`endif

/* hdl/hptc_pkg.sv */
`timescale 1ns / 1ps

package hptc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_TEMP_CAL    = 3'd0;
  localparam logic [2:0] REG_PRESS_CAL_A = 3'd1;
  localparam logic [2:0] REG_PRESS_CAL_B = 3'd2;
  localparam logic [2:0] REG_PRESS_CAL_C = 3'd3;
  localparam logic [2:0] REG_HUM_CAL_A   = 3'd4;
  localparam logic [2:0] REG_HUM_CAL_B   = 3'd5;

  localparam int QUOT_W = 64;

  // Decoded calibration coefficients.
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } cal_t;

  // One item on its way through the divider.
  typedef struct packed {
    logic               valid;
    logic [63:0]        un;     // dividend magnitude, then quotient
    logic [63:0]        ud;     // divisor magnitude
    logic               qneg;
    logic               zero;
    logic signed [18:0] temp;
    logic [16:0]        hum;
  } div_t;

  // Finished result payload.
  typedef struct packed {
    logic signed [18:0] temp;
    logic [31:0]        press;
    logic [16:0]        hum;
    logic               zero;
  } res_t;

endpackage

/* hdl/hptc_sample_if.sv */
`timescale 1ns / 1ps

interface hptc_sample_if;
  logic        valid;
  logic        ready;
  logic [19:0] temp_adc;
  logic [19:0] press_adc;
  logic [15:0] hum_adc;

  modport source (output valid, temp_adc, press_adc, hum_adc, input ready);
  modport sink (input valid, temp_adc, press_adc, hum_adc, output ready);
endinterface

/* hdl/hptc_result_if.sv */
`timescale 1ns / 1ps

interface hptc_result_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] temp_centi;
  logic [31:0]        press_q8;
  logic [16:0]        hum_q10;
  logic               press_div_zero;

  modport source (output valid, temp_centi, press_q8, hum_q10, press_div_zero,
                  input ready);
  modport sink (input valid, temp_centi, press_q8, hum_q10, press_div_zero,
                output ready);
endinterface

/* hdl/hptc_cfg_if.sv */
`timescale 1ns / 1ps

interface hptc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/hptc_front.sv */
`timescale 1ns / 1ps

// Temperature, humidity and the pressure dividend and divisor, twelve stages.
module hptc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [19:0]         temp_adc,
  input  logic [19:0]         press_adc,
  input  logic [15:0]         hum_adc,
  input  hptc_pkg::cal_t      cal,
  output hptc_pkg::div_t      dout
);

  logic [11:0] vld;

  logic signed [17:0] adiff;
  logic signed [16:0] tdiff;
  logic signed [31:0] s1_adt, s1_dd;
  logic signed [31:0] s2_a, s2_b;
  logic signed [31:0] s3_tf;
  logic signed [31:0] tt;
  logic signed [18:0] s4_temp, s5_temp, s6_temp, s7_temp, s8_temp;
  logic signed [18:0] s9_temp, s10_temp, s11_temp, s12_temp;
  logic signed [33:0] s4_v1;
  logic signed [31:0] s4_ha;
  logic signed [63:0] s5_vv, s5_v1p5, s5_v1p2;
  logic signed [31:0] s5_ah6, s5_ah3, s5_h5a;
  logic signed [63:0] s6_v2a, s6_v1c, s6_v1p5, s6_v1p2;
  logic signed [31:0] s6_y1, s6_x, x_sum, h4w;
  logic signed [63:0] s7_v2, s7_v1d, p4w;
  logic signed [31:0] s7_y3, s7_x;
  logic signed [63:0] s8_v1e, s8_v2;
  logic signed [31:0] s8_y, s8_x;
  logic [20:0]        pp;
  logic signed [63:0] s9_den, s9_nmr;
  logic signed [31:0] s9_r;
  logic signed [63:0] s10_num, s10_den;
  logic signed [31:0] s10_ss, s10_r;
  logic [63:0]        s11_un, s11_ud;
  logic               s11_qneg, s11_zero;
  logic signed [31:0] s11_t, s11_r, r2;
  logic [63:0]        s12_un, s12_ud;
  logic               s12_qneg, s12_zero;
  logic [16:0]        s12_hum;
  logic [19:0]        rp1, rp2, rp3, rp4, rp5, rp6, rp7, rp8;
  logic [15:0]        rh1, rh2, rh3, rh4, rh5;

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[10:0], in_valid};
    end
  end

  assign adiff = $signed({1'b0, temp_adc[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
  assign tdiff = $signed({1'b0, temp_adc[19:4]}) - $signed({1'b0, cal.t1});
  assign tt    = s3_tf * 32'sd5 + 32'sd128;
  assign h4w   = {{20{cal.h4[11]}}, cal.h4};
  assign x_sum = $signed({2'b00, rh5, 14'd0}) - (h4w <<< 20) - s5_h5a + 32'sd16384;
  assign p4w   = {{48{cal.p4[15]}}, cal.p4};
  assign pp    = 21'd1048576 - {1'b0, rp8};
  assign r2    = s11_r - (s11_t >>> 4);

  // Pipeline data registers.
  always_ff @(posedge clk) begin
    if (en) begin
      // Temperature products.
      s1_adt <= adiff * cal.t2;
      s1_dd  <= tdiff * tdiff;
      rp1 <= press_adc;
      rh1 <= hum_adc;
      s2_a <= s1_adt >>> 11;
      s2_b <= (s1_dd >>> 12) * cal.t3;
      rp2 <= rp1;
      rh2 <= rh1;
      s3_tf <= s2_a + (s2_b >>> 14);
      rp3 <= rp2;
      rh3 <= rh2;
      // Temperature out, and the offsets feeding pressure and humidity.
      s4_temp <= tt[26:8];
      s4_v1   <= {{2{s3_tf[31]}}, s3_tf} - 34'sd128000;
      s4_ha   <= s3_tf - 32'sd76800;
      rp4 <= rp3;
      rh4 <= rh3;
      s5_vv   <= s4_v1 * s4_v1;
      s5_v1p5 <= s4_v1 * cal.p5;
      s5_v1p2 <= s4_v1 * cal.p2;
      s5_ah6  <= s4_ha * cal.h6;
      s5_ah3  <= s4_ha * $signed({1'b0, cal.h3});
      s5_h5a  <= s4_ha * cal.h5;
      s5_temp <= s4_temp;
      rp5 <= rp4;
      rh5 <= rh4;
      s6_v2a  <= s5_vv * cal.p6;
      s6_v1c  <= s5_vv * cal.p3;
      s6_v1p5 <= s5_v1p5;
      s6_v1p2 <= s5_v1p2;
      s6_y1   <= (s5_ah6 >>> 10) * ((s5_ah3 >>> 11) + 32'sd32768);
      s6_x    <= x_sum >>> 15;
      s6_temp <= s5_temp;
      rp6 <= rp5;
      s7_v2   <= s6_v2a + (s6_v1p5 <<< 17) + (p4w <<< 35);
      s7_v1d  <= (s6_v1c >>> 8) + (s6_v1p2 <<< 12);
      s7_y3   <= ((s6_y1 >>> 10) + 32'sd2097152) * cal.h2;
      s7_x    <= s6_x;
      s7_temp <= s6_temp;
      rp7 <= rp6;
      s8_v1e  <= (64'sh0000_8000_0000_0000 + s7_v1d) * $signed({1'b0, cal.p1});
      s8_v2   <= s7_v2;
      s8_y    <= (s7_y3 + 32'sd16384) >>> 15;
      s8_x    <= s7_x;
      s8_temp <= s7_temp;
      rp8 <= rp7;
      // Divisor and the unscaled dividend.
      s9_den  <= s8_v1e >>> 33;
      s9_nmr  <= $signed({12'd0, pp, 31'd0}) - s8_v2;
      s9_r    <= s8_x * s8_y;
      s9_temp <= s8_temp;
      s10_num  <= s9_nmr * 64'sd3125;
      s10_den  <= s9_den;
      s10_ss   <= (s9_r >>> 15) * (s9_r >>> 15);
      s10_r    <= s9_r;
      s10_temp <= s9_temp;
      // Signs split off for the unsigned divider.
      s11_un   <= s10_num[63] ? (64'd0 - s10_num) : s10_num;
      s11_ud   <= s10_den[63] ? (64'd0 - s10_den) : s10_den;
      s11_qneg <= s10_num[63] ^ s10_den[63];
      s11_zero <= (s10_den == 64'sd0);
      s11_t    <= (s10_ss >>> 7) * $signed({1'b0, cal.h1});
      s11_r    <= s10_r;
      s11_temp <= s10_temp;
      // Humidity clamp and scale.
      s12_un   <= s11_un;
      s12_ud   <= s11_ud;
      s12_qneg <= s11_qneg;
      s12_zero <= s11_zero;
      s12_temp <= s11_temp;
      if (r2 < 32'sd0) begin
        s12_hum <= '0;
      end else if (r2 > 32'sd419430400) begin
        s12_hum <= 17'd102400;
      end else begin
        s12_hum <= r2[28:12];
      end
    end
  end

  assign dout.valid = vld[11];
  assign dout.un    = s12_un;
  assign dout.ud    = s12_ud;
  assign dout.qneg  = s12_qneg;
  assign dout.zero  = s12_zero;
  assign dout.temp  = s12_temp;
  assign dout.hum   = s12_hum;

endmodule

/* hdl/hptc_div.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage.
module hptc_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  hptc_pkg::div_t din,
  output hptc_pkg::div_t dout
);

  localparam int N = hptc_pkg::QUOT_W;

  hptc_pkg::div_t st  [0:N];
  logic [63:0]    rem [0:N-1];

  assign st[0]  = din;
  assign rem[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_bit
    logic [63:0]    rem_s;
    logic           ge;
    hptc_pkg::div_t st_next;

    // The remainder stays below the divisor, so its top bit is free.
    assign rem_s = {rem[k][62:0], st[k].un[63]};
    assign ge    = (rem_s >= st[k].ud);

    // The quotient bit shifts in as the dividend shifts out.
    always_comb begin
      st_next    = st[k];
      st_next.un = {st[k].un[62:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k+1].valid <= 1'b0;
      end else if (en) begin
        st[k+1] <= st_next;
      end
    end

    // The last stage needs no remainder.
    if (k < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? (rem_s - st[k].ud) : rem_s;
        end
      end
    end
  end

  assign dout = st[N];

endmodule

/* hdl/hptc_post.sv */
`timescale 1ns / 1ps

// Pressure refinement after the divide, six stages.
module hptc_post (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  hptc_pkg::div_t din,
  input  hptc_pkg::cal_t cal,
  output logic           out_valid,
  output hptc_pkg::res_t dout
);

  logic [5:0] vld;

  logic signed [18:0] tp [0:5];
  logic [16:0]        hm [0:5];
  logic               zr [0:5];

  logic signed [63:0] p0, p1_p, p2_p, p3_p, p4_s;
  logic signed [63:0] q;
  logic [63:0]        p1_ll, p2_qq;
  logic [31:0]        p1_x;
  logic signed [63:0] p1_p8p, p2_p8p, p3_p8p, p3_m;
  logic signed [63:0] p7w, fin;
  logic [31:0]        p5_press;

  assign q   = p0 >>> 13;
  assign p7w = {{48{cal.p7[15]}}, cal.p7};
  assign fin = (p4_s >>> 8) + (p7w <<< 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], din.valid};
    end
  end

  // Side fields ride along.
  always_ff @(posedge clk) begin
    if (en) begin
      tp[0] <= din.temp;
      hm[0] <= din.hum;
      zr[0] <= din.zero;
      for (int i = 1; i < 6; i++) begin
        tp[i] <= tp[i-1];
        hm[i] <= hm[i-1];
        zr[i] <= zr[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Restore the quotient sign.
      p0 <= din.qneg ? (64'd0 - din.un) : din.un;
      // Square of p >> 13 in 32-bit partial products.
      p1_ll  <= {32'd0, q[31:0]} * {32'd0, q[31:0]};
      p1_x   <= q[31:0] * q[63:32];
      p1_p8p <= p0 * cal.p8;
      p1_p   <= p0;
      p2_qq  <= p1_ll + {p1_x[30:0], 33'd0};
      p2_p8p <= p1_p8p;
      p2_p   <= p1_p;
      p3_m   <= $signed(p2_qq) * cal.p9;
      p3_p8p <= p2_p8p;
      p3_p   <= p2_p;
      p4_s   <= p3_p + (p3_m >>> 25) + (p3_p8p >>> 19);
      p5_press <= zr[4] ? 32'd0 : fin[31:0];
    end
  end

  assign out_valid  = vld[5];
  assign dout.temp  = tp[5];
  assign dout.hum   = hm[5];
  assign dout.zero  = zr[5];
  assign dout.press = p5_press;

endmodule

/* hdl/humidity_pressure_temp_compensation.sv */
`timescale 1ns / 1ps
// A sample's result passes 12 front, 64 divider, 6 post and 1 buffer stage
// on its way from the edge that accepts the sample to the result port.
// Throughput: one sample per cycle while the output buffer is not full; the 64-stage divider sets the depth.
// A two-entry output buffer keeps samples flowing while a result waits.
// Reset (rst, synchronous) clears valid bits and all calibration registers.
// The configuration port is always ready.
module humidity_pressure_temp_compensation (
  input  logic   clk,
  input  logic   rst,
  hptc_sample_if.sink   sample,
  hptc_result_if.source result,
  hptc_cfg_if.sink      cfg
);

  logic [47:0] temp_cal, press_cal_a, press_cal_b, press_cal_c;
  logic [31:0] hum_cal_a, hum_cal_b;

  hptc_pkg::cal_t cal;
  hptc_pkg::div_t front_out, div_out;
  hptc_pkg::res_t post_out, slot0, slot1;
  logic           post_valid;
  logic           en, push, pop;
  logic [1:0]     cnt;

  // Calibration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal    <= '0;
      press_cal_a <= '0;
      press_cal_b <= '0;
      press_cal_c <= '0;
      hum_cal_a   <= '0;
      hum_cal_b   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        hptc_pkg::REG_TEMP_CAL:    temp_cal    <= cfg.data;
        hptc_pkg::REG_PRESS_CAL_A: press_cal_a <= cfg.data;
        hptc_pkg::REG_PRESS_CAL_B: press_cal_b <= cfg.data;
        hptc_pkg::REG_PRESS_CAL_C: press_cal_c <= cfg.data;
        hptc_pkg::REG_HUM_CAL_A:   hum_cal_a   <= cfg.data[31:0];
        hptc_pkg::REG_HUM_CAL_B:   hum_cal_b   <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // Coefficient fields.
  assign cal.t1 = temp_cal[15:0];
  assign cal.t2 = temp_cal[31:16];
  assign cal.t3 = temp_cal[47:32];
  assign cal.p1 = press_cal_a[15:0];
  assign cal.p2 = press_cal_a[31:16];
  assign cal.p3 = press_cal_a[47:32];
  assign cal.p4 = press_cal_b[15:0];
  assign cal.p5 = press_cal_b[31:16];
  assign cal.p6 = press_cal_b[47:32];
  assign cal.p7 = press_cal_c[15:0];
  assign cal.p8 = press_cal_c[31:16];
  assign cal.p9 = press_cal_c[47:32];
  assign cal.h1 = hum_cal_a[7:0];
  assign cal.h2 = hum_cal_a[23:8];
  assign cal.h3 = hum_cal_a[31:24];
  assign cal.h4 = hum_cal_b[11:0];
  assign cal.h5 = hum_cal_b[23:12];
  assign cal.h6 = hum_cal_b[31:24];

  // The pipeline moves unless the output buffer is full.
  assign en           = (cnt != 2'd2);
  assign sample.ready = en;

  hptc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample.valid),
    .temp_adc  (sample.temp_adc),
    .press_adc (sample.press_adc),
    .hum_adc   (sample.hum_adc),
    .cal       (cal),
    .dout      (front_out)
  );

  hptc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (front_out),
    .dout (div_out)
  );

  hptc_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .din       (div_out),
    .cal       (cal),
    .out_valid (post_valid),
    .dout      (post_out)
  );

  // Two-entry output buffer; slot0 drives the port.
  assign push = en && post_valid;
  assign pop  = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt == 2'd2) begin
        slot0 <= slot1;
      end else if (push) begin
        slot0 <= post_out;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        slot0 <= post_out;
      end else begin
        slot1 <= post_out;
      end
    end
  end

  assign result.valid          = (cnt != 2'd0);
  assign result.temp_centi     = slot0.temp;
  assign result.press_q8       = slot0.press;
  assign result.hum_q10        = slot0.hum;
  assign result.press_div_zero = slot0.zero;

endmodule

/* hdl/hptc_check.sv */
`timescale 1ns / 1ps
`include "humidity_pressure_temp_compensation_assert.svh"

// Port-level checks for the compensation block.
module hptc_check (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] press_q8,
  input logic [16:0] hum_q10,
  input logic        press_div_zero,
  input logic        cfg_ready
);

  // A held result stays offered.
  `HPTC_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid)
  // A zero divisor always reports zero pressure.
  `HPTC_ASSERT(a_zero_press, res_valid && press_div_zero |-> press_q8 == 32'd0)
  // Humidity never leaves its clamp range.
  `HPTC_ASSERT(a_hum_range, res_valid |-> hum_q10 <= 17'd102400)
  // Nothing is offered right after reset.
  `HPTC_ASSERT_ALWAYS(a_rst_empty, rst |=> !res_valid)
  // Configuration is never back-pressured.
  `HPTC_ASSERT_ALWAYS(a_cfg_ready, cfg_ready)

endmodule

bind humidity_pressure_temp_compensation hptc_check u_hptc_check (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .press_q8       (result.press_q8),
  .hum_q10        (result.hum_q10),
  .press_div_zero (result.press_div_zero),
  .cfg_ready      (cfg.ready)
);
